// ----- hw/rtl/matrix_multiply_engine_macros.svh -----
// Assertion macros used by the checker file mme_checker.sv.
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MME_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("matrix multiply engine: assertion failed");

// Check a property on every clock edge, reset included.
`define MME_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("matrix multiply engine: assertion failed");

`endif

// ----- hw/rtl/mme_pkg.sv -----
package mme_pkg;

    // Field widths
    localparam int VALUE_W     = 16;
    localparam int ELEM_W      = 32;
    localparam int IDX_W       = 3;
    localparam int FUNC_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int ROWS_CFG_W  = 4;
    localparam int INNER_CFG_W = 5;
    localparam int COLS_CFG_W  = 4;

    // Function codes of an input beat
    localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd2;

    // Configuration reset values
    localparam logic [ROWS_CFG_W-1:0]  ROWS_RST  = 4'd8;
    localparam logic [INNER_CFG_W-1:0] INNER_RST = 5'd16;
    localparam logic [COLS_CFG_W-1:0]  COLS_RST  = 4'd8;

    // Saturation limits of a product element
    localparam logic [ELEM_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] ELEM_MIN = 32'h8000_0000;

    // Control of the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctl_t;

endpackage

// ----- hw/rtl/mme_ram.sv -----
module mme_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/mme_mac.sv -----
module mme_mac #(
    parameter int ACC_W = 37
) (
    input  logic                             clk,
    input  logic                             rstn,
    input  mme_pkg::mac_ctl_t                ctl,
    input  logic signed [mme_pkg::VALUE_W-1:0] op_a,
    input  logic signed [mme_pkg::VALUE_W-1:0] op_b,
    output logic                             busy,
    output logic [mme_pkg::ELEM_W-1:0]       sat_out
);

    localparam int PROD_W = 2 * mme_pkg::VALUE_W;
    localparam int HI_W   = ACC_W - mme_pkg::ELEM_W + 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [HI_W-1:0]          acc_hi;

    // Multiply stage
    always_ff @(posedge clk) begin
        if (!rstn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk) begin
        prod_reg <= op_a * op_b;
    end

    // Accumulate stage; clear starts a new sum
    always_ff @(posedge clk) begin
        if (ctl.clear) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Saturate the sum to the element range
    assign acc_hi = acc_reg[ACC_W-1:mme_pkg::ELEM_W-1];

    always_comb begin
        if ((&acc_hi) || !(|acc_hi)) begin
            sat_out = acc_reg[mme_pkg::ELEM_W-1:0];
        end else if (acc_reg[ACC_W-1]) begin
            sat_out = mme_pkg::ELEM_MIN;
        end else begin
            sat_out = mme_pkg::ELEM_MAX;
        end
    end

    assign busy = prod_vld_reg;

endmodule

// ----- hw/rtl/matrix_multiply_engine.sv -----
// Fixed-point matrix multiply. Load beats (func 0 for A, func 1 for B) write
// one signed Q8.8 element each in row-major order; the load position wraps
// after the last element of the configured matrix. A compute beat walks
// every product element, row by row, on one shared multiply-accumulate unit
// fed by the registered read ports of the two element memories: for each
// element the sequencer issues inner_len pairs of reads, then drains the
// pipeline and hands the sum to the output register once that is free.
// Sums are kept exactly and saturated to signed Q16.16. The input side
// is not ready while a compute runs; the final result may still wait in the
// output register while the next beat is taken. Element memories start
// undefined and need no clearing; read only elements that were loaded.
module matrix_multiply_engine #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_INNER = 16,
    parameter int MAX_COLS  = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [mme_pkg::FUNC_W-1:0]         s_func,
    input  logic signed [mme_pkg::VALUE_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mme_pkg::ELEM_W-1:0]  m_element,
    output logic [mme_pkg::IDX_W-1:0]          m_row,
    output logic [mme_pkg::IDX_W-1:0]          m_col,
    output logic                               m_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mme_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mme_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
    localparam int B_DEPTH = MAX_INNER * MAX_COLS;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int A_CW    = $clog2(A_DEPTH + 1);
    localparam int B_CW    = $clog2(B_DEPTH + 1);
    localparam int RW      = $clog2(MAX_ROWS + 1);
    localparam int IW      = $clog2(MAX_INNER + 1);
    localparam int CLW     = $clog2(MAX_COLS + 1);
    localparam int RIW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int KW      = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int CIW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ACC_W   = 2 * mme_pkg::VALUE_W + $clog2(MAX_INNER) + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // Configuration registers
    logic [mme_pkg::ROWS_CFG_W-1:0]  num_rows_reg;
    logic [mme_pkg::INNER_CFG_W-1:0] inner_len_reg;
    logic [mme_pkg::COLS_CFG_W-1:0]  num_cols_reg;

    // Sequencer state
    logic [1:0]      state_reg, state_next;
    logic [RIW-1:0]  row_reg, row_next;
    logic [CIW-1:0]  col_reg, col_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [A_AW-1:0] a_base_reg, a_base_next;
    logic [A_AW-1:0] a_addr_reg, a_addr_next;
    logic [B_AW-1:0] b_addr_reg, b_addr_next;
    logic [A_AW-1:0] a_idx_reg, a_idx_next;
    logic [B_AW-1:0] b_idx_reg, b_idx_next;
    logic            rd_vld_reg;

    // Output register
    logic                        m_valid_reg, m_valid_next;
    logic [mme_pkg::ELEM_W-1:0]  m_element_reg;
    logic [mme_pkg::IDX_W-1:0]   m_row_reg;
    logic [mme_pkg::IDX_W-1:0]   m_col_reg;
    logic                        m_last_reg;

    // Derived dimensions and load positions
    logic [RW-1:0]   rows_cl, rows_m1;
    logic [IW-1:0]   inner_cl, inner_m1;
    logic [CLW-1:0]  cols_cl, cols_m1;
    logic [A_CW-1:0] a_count, a_pos_inc;
    logic [B_CW-1:0] b_count, b_pos_inc;
    logic [A_AW-1:0] a_pos, a_idx_adv;
    logic [B_AW-1:0] b_pos, b_idx_adv;
    logic            row_is_last, col_is_last, k_is_last, elem_last;
    logic            a_we, b_we, out_load;

    logic [mme_pkg::VALUE_W-1:0] a_rd_data, b_rd_data;
    logic [mme_pkg::ELEM_W-1:0]  mac_sat;
    logic                        mac_busy;
    mme_pkg::mac_ctl_t           mac_ctl;

    // Clamp register values into 1..maximum
    always_comb begin
        if (num_rows_reg == '0) begin
            rows_cl = RW'(1);
        end else if (num_rows_reg > MAX_ROWS) begin
            rows_cl = RW'(MAX_ROWS);
        end else begin
            rows_cl = RW'(num_rows_reg);
        end
        if (inner_len_reg == '0) begin
            inner_cl = IW'(1);
        end else if (inner_len_reg > MAX_INNER) begin
            inner_cl = IW'(MAX_INNER);
        end else begin
            inner_cl = IW'(inner_len_reg);
        end
        if (num_cols_reg == '0) begin
            cols_cl = CLW'(1);
        end else if (num_cols_reg > MAX_COLS) begin
            cols_cl = CLW'(MAX_COLS);
        end else begin
            cols_cl = CLW'(num_cols_reg);
        end
    end

    assign rows_m1  = rows_cl - RW'(1);
    assign inner_m1 = inner_cl - IW'(1);
    assign cols_m1  = cols_cl - CLW'(1);

    assign row_is_last = (RW'(row_reg) == rows_m1);
    assign col_is_last = (CLW'(col_reg) == cols_m1);
    assign k_is_last   = (IW'(k_reg) == inner_m1);
    assign elem_last   = row_is_last && col_is_last;

    // Load positions: restart at zero when out of range, wrap after the last
    assign a_count   = A_CW'(rows_cl) * A_CW'(inner_cl);
    assign a_pos     = (A_CW'(a_idx_reg) >= a_count) ? '0 : a_idx_reg;
    assign a_pos_inc = A_CW'(a_pos) + A_CW'(1);
    assign a_idx_adv = (a_pos_inc >= a_count) ? '0 : A_AW'(a_pos_inc);

    assign b_count   = B_CW'(inner_cl) * B_CW'(cols_cl);
    assign b_pos     = (B_CW'(b_idx_reg) >= b_count) ? '0 : b_idx_reg;
    assign b_pos_inc = B_CW'(b_pos) + B_CW'(1);
    assign b_idx_adv = (b_pos_inc >= b_count) ? '0 : B_AW'(b_pos_inc);

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign a_we      = s_valid && s_ready && (s_func == mme_pkg::FUNC_LOAD_A);
    assign b_we      = s_valid && s_ready && (s_func == mme_pkg::FUNC_LOAD_B);

    // Sequencer: loads, then per element a run of reads and a drain
    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        k_next        = k_reg;
        a_base_next   = a_base_reg;
        a_addr_next   = a_addr_reg;
        b_addr_next   = b_addr_reg;
        a_idx_next    = a_idx_reg;
        b_idx_next    = b_idx_reg;
        out_load      = 1'b0;
        mac_ctl.valid = rd_vld_reg;
        mac_ctl.clear = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_func)
                        mme_pkg::FUNC_LOAD_A: begin
                            a_idx_next = a_idx_adv;
                        end
                        mme_pkg::FUNC_LOAD_B: begin
                            b_idx_next = b_idx_adv;
                        end
                        mme_pkg::FUNC_COMPUTE: begin
                            state_next    = ST_RUN;
                            row_next      = '0;
                            col_next      = '0;
                            k_next        = '0;
                            a_base_next   = '0;
                            a_addr_next   = '0;
                            b_addr_next   = '0;
                            mac_ctl.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                // Issue one pair of reads per cycle
                if (k_is_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next      = k_reg + KW'(1);
                    a_addr_next = a_addr_reg + A_AW'(1);
                    b_addr_next = b_addr_reg + B_AW'(cols_cl);
                end
            end
            ST_DRAIN: begin
                // Hand the finished sum to the output and start the next element
                if (!rd_vld_reg && !mac_busy && (!m_valid_reg || m_ready)) begin
                    out_load = 1'b1;
                    if (elem_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next    = ST_RUN;
                        mac_ctl.clear = 1'b1;
                        k_next        = '0;
                        if (col_is_last) begin
                            col_next    = '0;
                            row_next    = row_reg + RIW'(1);
                            a_base_next = a_base_reg + A_AW'(inner_cl);
                            a_addr_next = a_base_reg + A_AW'(inner_cl);
                            b_addr_next = '0;
                        end else begin
                            col_next    = col_reg + CIW'(1);
                            a_addr_next = a_base_reg;
                            b_addr_next = B_AW'(col_reg) + B_AW'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until taken
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            a_base_reg    <= '0;
            a_addr_reg    <= '0;
            b_addr_reg    <= '0;
            a_idx_reg     <= '0;
            b_idx_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            num_rows_reg  <= mme_pkg::ROWS_RST;
            inner_len_reg <= mme_pkg::INNER_RST;
            num_cols_reg  <= mme_pkg::COLS_RST;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            k_reg       <= k_next;
            a_base_reg  <= a_base_next;
            a_addr_reg  <= a_addr_next;
            b_addr_reg  <= b_addr_next;
            a_idx_reg   <= a_idx_next;
            b_idx_reg   <= b_idx_next;
            rd_vld_reg  <= (state_reg == ST_RUN);
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mme_pkg::CFG_NUM_ROWS: begin
                        num_rows_reg <= cfg_data[mme_pkg::ROWS_CFG_W-1:0];
                    end
                    mme_pkg::CFG_INNER_LEN: begin
                        inner_len_reg <= cfg_data[mme_pkg::INNER_CFG_W-1:0];
                    end
                    mme_pkg::CFG_NUM_COLS: begin
                        num_cols_reg <= cfg_data[mme_pkg::COLS_CFG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_element_reg <= mac_sat;
            m_row_reg     <= mme_pkg::IDX_W'(row_reg);
            m_col_reg     <= mme_pkg::IDX_W'(col_reg);
            m_last_reg    <= elem_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_element = m_element_reg;
    assign m_row     = m_row_reg;
    assign m_col     = m_col_reg;
    assign m_last    = m_last_reg;

    mme_ram #(
        .DATA_W (mme_pkg::VALUE_W),
        .DEPTH  (A_DEPTH),
        .ADDR_W (A_AW)
    ) u_a_ram (
        .clk     (aclk),
        .wr_en   (a_we),
        .wr_addr (a_pos),
        .wr_data (s_value),
        .rd_addr (a_addr_reg),
        .rd_data (a_rd_data)
    );

    mme_ram #(
        .DATA_W (mme_pkg::VALUE_W),
        .DEPTH  (B_DEPTH),
        .ADDR_W (B_AW)
    ) u_b_ram (
        .clk     (aclk),
        .wr_en   (b_we),
        .wr_addr (b_pos),
        .wr_data (s_value),
        .rd_addr (b_addr_reg),
        .rd_data (b_rd_data)
    );

    mme_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk     (aclk),
        .rstn    (aresetn),
        .ctl     (mac_ctl),
        .op_a    ($signed(a_rd_data)),
        .op_b    ($signed(b_rd_data)),
        .busy    (mac_busy),
        .sat_out (mac_sat)
    );

endmodule

// ----- hw/rtl/mme_checker.sv -----
`include "matrix_multiply_engine_macros.svh"

module mme_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [mme_pkg::FUNC_W-1:0]         s_func,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [mme_pkg::ELEM_W-1:0]  m_element,
    input logic [mme_pkg::IDX_W-1:0]          m_row,
    input logic [mme_pkg::IDX_W-1:0]          m_col,
    input logic                               m_last
);

    // Reset empties the output register
    `MME_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid)

    // A stalled result beat holds
    `MME_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_element) && $stable(m_row) && $stable(m_col) && $stable(m_last))

    // A compute beat closes the input side
    `MME_ASSERT(a_compute_busy, aclk, aresetn, s_valid && s_ready && s_func == mme_pkg::FUNC_COMPUTE |=> !s_ready)

    // While a non-final element waits, the compute is still running
    `MME_ASSERT(a_mid_product_busy, aclk, aresetn, m_valid && !m_last |-> !s_ready)

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);

// ----- tb/sv/mme_product_checker.sv -----
`timescale 1ns / 100ps

module mme_product_checker #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_INNER = 16,
    parameter int MAX_COLS  = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [mme_pkg::FUNC_W-1:0]         s_func,
    input  logic signed [mme_pkg::VALUE_W-1:0] s_value,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [mme_pkg::ELEM_W-1:0]  m_element,
    input  logic [mme_pkg::IDX_W-1:0]          m_row,
    input  logic [mme_pkg::IDX_W-1:0]          m_col,
    input  logic                               m_last,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [mme_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mme_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 mismatches,
    output int                                 elems_owed
);
    import mme_pkg::*;

    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic                     last;
    } product_elem_t;

    // Shadow copy of the element memories, load positions and dimensions
    logic signed [VALUE_W-1:0] a_elems [MAX_ROWS*MAX_INNER];
    logic signed [VALUE_W-1:0] b_elems [MAX_INNER*MAX_COLS];
    int                        a_pos;
    int                        b_pos;
    logic [ROWS_CFG_W-1:0]     rows_reg;
    logic [INNER_CFG_W-1:0]    inner_reg;
    logic [COLS_CFG_W-1:0]     cols_reg;

    // Product elements still owed by the block, oldest first
    product_elem_t product_q[$];

    initial begin
        mismatches = 0;
        elems_owed = 0;
    end

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic int eff_dim(int raw, int limit);
        if (raw == 0) return 1;
        return (raw > limit) ? limit : raw;
    endfunction

    function automatic int wrap_pos(int pos, int count);
        return (pos >= count) ? 0 : pos;
    endfunction

    // Queue every element of A*B, row by row, saturated to Q16.16
    task automatic predict_product(int rows, int inner, int cols);
        product_elem_t e;
        longint        acc;
        for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) begin
                acc = 0;
                for (int k = 0; k < inner; k++) begin
                    acc += longint'(a_elems[i*inner + k]) *
                           longint'(b_elems[k*cols + j]);
                end
                if (acc > 64'sd2147483647) begin
                    e.element = ELEM_MAX;
                end else if (acc < -64'sd2147483648) begin
                    e.element = ELEM_MIN;
                end else begin
                    e.element = acc[ELEM_W-1:0];
                end
                e.row  = i[IDX_W-1:0];
                e.col  = j[IDX_W-1:0];
                e.last = (i == rows - 1) && (j == cols - 1);
                product_q.push_back(e);
            end
        end
    endtask

    always @(posedge aclk) begin
        product_elem_t want;
        int            rows;
        int            inner;
        int            cols;
        int            p;
        if (!aresetn) begin
            a_pos     = 0;
            b_pos     = 0;
            rows_reg  = ROWS_RST;
            inner_reg = INNER_RST;
            cols_reg  = COLS_RST;
            product_q.delete();
        end else begin
            // Compare each result beat against the oldest prediction
            if (m_valid && m_ready) begin
                if (product_q.size() == 0) begin
                    mismatches++;
                    $display({"%0t: result beat with nothing expected:",
                              " element %0d row %0d col %0d last %0b"},
                             $time, m_element, m_row, m_col, m_last);
                end else begin
                    want = product_q.pop_front();
                    if (want.element !== m_element || want.row !== m_row ||
                        want.col !== m_col || want.last !== m_last) begin
                        mismatches++;
                        $display({"%0t: product mismatch: expected element %0d row %0d",
                                  " col %0d last %0b, got element %0d row %0d col %0d",
                                  " last %0b"},
                                 $time, want.element, want.row, want.col, want.last,
                                 m_element, m_row, m_col, m_last);
                    end
                end
            end

            // Track register writes; an unused index writes nothing
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NUM_ROWS:  rows_reg  = cfg_data[ROWS_CFG_W-1:0];
                    CFG_INNER_LEN: inner_reg = cfg_data[INNER_CFG_W-1:0];
                    CFG_NUM_COLS:  cols_reg  = cfg_data[COLS_CFG_W-1:0];
                    default: ;
                endcase
            end

            // Apply each input beat: store an element or predict a product
            if (s_valid && s_ready) begin
                rows  = eff_dim(int'(rows_reg), MAX_ROWS);
                inner = eff_dim(int'(inner_reg), MAX_INNER);
                cols  = eff_dim(int'(cols_reg), MAX_COLS);
                case (s_func)
                    FUNC_LOAD_A: begin
                        p          = wrap_pos(a_pos, rows * inner);
                        a_elems[p] = s_value;
                        a_pos      = wrap_pos(p + 1, rows * inner);
                    end
                    FUNC_LOAD_B: begin
                        p          = wrap_pos(b_pos, inner * cols);
                        b_elems[p] = s_value;
                        b_pos      = wrap_pos(p + 1, inner * cols);
                    end
                    FUNC_COMPUTE: predict_product(rows, inner, cols);
                    default: ;
                endcase
            end
        end
        elems_owed = product_q.size();
    end

endmodule

// ----- tb/sv/tb_matrix_multiply_engine.sv -----
`timescale 1ns / 100ps

module tb_matrix_multiply_engine;
    import mme_pkg::*;

    localparam int MAX_ROWS     = 8;
    localparam int MAX_INNER    = 16;
    localparam int MAX_COLS     = 8;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;

    // Codes the package leaves unnamed
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    logic [FUNC_W-1:0]        s_func    = FUNC_LOAD_A;
    logic signed [VALUE_W-1:0] s_value  = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    logic signed [ELEM_W-1:0] m_element;
    logic [IDX_W-1:0]         m_row;
    logic [IDX_W-1:0]         m_col;
    logic                     m_last;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_NUM_ROWS;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;

    int mismatches;
    int elems_owed;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;
    int items_done    = 0;

    // Which elements have been loaded, so a compute never reads an empty one
    int eff_rows  = MAX_ROWS;
    int eff_inner = MAX_INNER;
    int eff_cols  = MAX_COLS;
    int a_next    = 0;
    int b_next    = 0;
    bit a_seen [MAX_ROWS*MAX_INNER];
    bit b_seen [MAX_INNER*MAX_COLS];

    matrix_multiply_engine #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_element (m_element),
        .m_row     (m_row),
        .m_col     (m_col),
        .m_last    (m_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mme_product_checker #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS)
    ) i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_element  (m_element),
        .m_row      (m_row),
        .m_col      (m_col),
        .m_last     (m_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .elems_owed (elems_owed)
    );

    always #2 aclk = ~aclk;

    // Result side: random backpressure, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // End the run when no beat moves on any channel for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
                $display("** matrix_multiply_engine: FAILED **");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic int clamp_dim(int raw, int limit);
        if (raw == 0) return 1;
        return (raw > limit) ? limit : raw;
    endfunction

    // Full-range values half the time, with the extremes and small values mixed in
    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return VALUE_W'($urandom_range(0, 1023) - 512);
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic bit compute_ok();
        for (int p = 0; p < eff_rows * eff_inner; p++)
            if (!a_seen[p]) return 0;
        for (int p = 0; p < eff_inner * eff_cols; p++)
            if (!b_seen[p]) return 0;
        return 1;
    endfunction

    // Offer one input beat and return at the edge where it is taken
    task automatic send_beat(logic [FUNC_W-1:0] f, logic signed [VALUE_W-1:0] v);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= f;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Send a beat and follow the load positions it moves
    task automatic issue(logic [FUNC_W-1:0] f, logic signed [VALUE_W-1:0] v);
        int cnt;
        int p;
        send_beat(f, v);
        if (f == FUNC_LOAD_A) begin
            cnt       = eff_rows * eff_inner;
            p         = (a_next >= cnt) ? 0 : a_next;
            a_seen[p] = 1'b1;
            a_next    = (p + 1 >= cnt) ? 0 : p + 1;
        end else if (f == FUNC_LOAD_B) begin
            cnt       = eff_inner * eff_cols;
            p         = (b_next >= cnt) ? 0 : b_next;
            b_seen[p] = 1'b1;
            b_next    = (p + 1 >= cnt) ? 0 : p + 1;
        end
        if (f != FUNC_UNUSED) items_done++;
    endtask

    task automatic load_a(int n);
        repeat (n) issue(FUNC_LOAD_A, rand_value());
    endtask

    task automatic load_b(int n);
        repeat (n) issue(FUNC_LOAD_B, rand_value());
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Write all three dimensions; bits above each register are random
    task automatic set_dims(int r, int i, int c, bit with_unused);
        logic [CFG_DATA_W-1:0] d;
        if (with_unused || $urandom_range(0, 7) == 0)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 255)));
        d = CFG_DATA_W'($urandom_range(0, 255));
        d[ROWS_CFG_W-1:0] = ROWS_CFG_W'(r);
        write_reg(CFG_NUM_ROWS, d);
        d = CFG_DATA_W'($urandom_range(0, 255));
        d[INNER_CFG_W-1:0] = INNER_CFG_W'(i);
        write_reg(CFG_INNER_LEN, d);
        d = CFG_DATA_W'($urandom_range(0, 255));
        d[COLS_CFG_W-1:0] = COLS_CFG_W'(c);
        write_reg(CFG_NUM_COLS, d);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        eff_rows  = clamp_dim(r, MAX_ROWS);
        eff_inner = clamp_dim(i, MAX_INNER);
        eff_cols  = clamp_dim(c, MAX_COLS);
    endtask

    // Drop valid, wait out all owed results, then let trailing loads settle
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (elems_owed != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Mostly complete load-and-compute sequences, sometimes loose beats
    task automatic run_sequence();
        logic [FUNC_W-1:0] f;
        if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 1)) begin
                load_a(eff_rows * eff_inner);
                load_b(eff_inner * eff_cols);
            end else begin
                load_b(eff_inner * eff_cols);
                load_a(eff_rows * eff_inner);
            end
            issue(FUNC_COMPUTE, rand_value());
            if ($urandom_range(0, 4) == 0) issue(FUNC_COMPUTE, rand_value());
        end else begin
            repeat ($urandom_range(1, 6)) begin
                f = FUNC_W'($urandom_range(0, 3));
                // Load instead of a compute that would read an element never loaded
                if (f == FUNC_COMPUTE && !compute_ok()) f = FUNC_LOAD_A;
                issue(f, rand_value());
            end
            if (compute_ok()) issue(FUNC_COMPUTE, rand_value());
        end
    endtask

    task automatic run_random(int goal, int tx_pct, int rx_pct);
        int stop_at;
        int r;
        int i;
        int c;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = items_done + goal;
        while (items_done < stop_at) begin
            r = $urandom_range(1, 4);
            i = $urandom_range(1, 6);
            c = $urandom_range(1, 4);
            case ($urandom_range(0, 7))
                0: begin
                    // rows and columns zero or at or past the maximum
                    r = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_ROWS, 15);
                    c = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_COLS, 15);
                    i = $urandom_range(1, 3);
                end
                1: begin
                    // inner length zero or at or past the maximum
                    i = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_INNER, 31);
                    r = $urandom_range(1, 2);
                    c = $urandom_range(1, 2);
                end
                default: ;
            endcase
            wait_idle();
            set_dims(r, i, c, 1'b0);
            repeat ($urandom_range(1, 3)) run_sequence();
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 23;
        rx_idle_pct = 77;

        // 2x3 times 3x2: saturate high and low in row 0
        set_dims(2, 3, 2, 1'b0);
        repeat (3) issue(FUNC_LOAD_A, 16'sh8000);
        issue(FUNC_LOAD_A, 16'sh7FFF);
        issue(FUNC_LOAD_A, 16'sh0001);
        issue(FUNC_LOAD_A, 16'shFFFF);
        repeat (3) begin
            issue(FUNC_LOAD_B, 16'sh8000);
            issue(FUNC_LOAD_B, 16'sh7FFF);
        end
        issue(FUNC_COMPUTE, 16'sh0000);
        issue(FUNC_UNUSED, 16'sh5555);
        issue(FUNC_COMPUTE, 16'shAAAA);

        // Leave A part-loaded, then shrink so the next load lands at zero
        issue(FUNC_LOAD_A, 16'sh00FF);
        issue(FUNC_LOAD_A, 16'shFF00);
        issue(FUNC_LOAD_A, 16'sh0100);
        issue(FUNC_LOAD_A, 16'sh5A5A);
        wait_idle();
        set_dims(0, 0, 0, 1'b1);
        issue(FUNC_LOAD_A, 16'sh7FFF);
        issue(FUNC_LOAD_B, 16'sh7FFF);
        issue(FUNC_COMPUTE, 16'sh0000);

        run_random(30, 23, 77);
        run_random(30, 77, 23);

        tx_idle_pct = 0;
        rx_idle_pct = 0;

        // 64 results with the receiver held off so the input stalls
        wait_idle();
        set_dims(MAX_ROWS, 1, MAX_COLS, 1'b0);
        load_a(MAX_ROWS);
        load_b(MAX_COLS);
        hold_requests++;
        issue(FUNC_COMPUTE, rand_value());
        load_a(MAX_ROWS);
        issue(FUNC_COMPUTE, rand_value());

        // Full A memory, every dimension set through an out-of-range value
        wait_idle();
        set_dims(15, 31, 0, 1'b0);
        load_a(MAX_ROWS * MAX_INNER);
        load_b(MAX_INNER);
        issue(FUNC_COMPUTE, rand_value());

        run_random(30, 0, 0);

        wait_idle();
        repeat (4 * DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && elems_owed == 0) begin
            $display("** matrix_multiply_engine: PASSED **");
        end else begin
            $display("** matrix_multiply_engine: FAILED **");
        end
        $finish;
    end

endmodule
